/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds whenever reset is released
`define IAAS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`endif

/* rtl/iaas_pkg.sv */
// ----------------------------------------------------------------------------
// iaas_pkg: shared types and constants
// Sizes, register indexes, the sequencer state type and the divider request and response types of the scaler.
// ----------------------------------------------------------------------------
package iaas_pkg;
	localparam int MaxWidth  = 512;
	localparam int MaxHeight = 512;
	localparam int XW = $clog2(MaxWidth);
	localparam int YW = $clog2(MaxHeight);
	localparam int AW = XW + YW;
	localparam int SumW = 8 + AW + 1;
	localparam int CntW = AW + 1;

	// divider sized for a channel sum over a full-frame box
	localparam int DivNW   = SumW;
	localparam int DivDW   = CntW;
	localparam int DivCntW = $clog2(DivNW + 1);

	localparam logic [2:0] RegSrcW = 3'd0;
	localparam logic [2:0] RegSrcH = 3'd1;
	localparam logic [2:0] RegDstW = 3'd2;
	localparam logic [2:0] RegDstH = 3'd3;
	localparam logic [2:0] RegNear = 3'd4;
	localparam logic [2:0] RegFour = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_XA, ST_XB, ST_YA, ST_YB, ST_RD, ST_ACC, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DivNW-1:0] dividend;
		logic [DivDW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DivNW-1:0] quot;
	} div_rsp_t;
endpackage

/* rtl/image_area_average_scaler.sv */
// Loads: a load word is written at its accepting edge; one per cycle unless stalled.
// Compute, area mode: four bound divides, a sum over the box, then four mean divides.
// Compute, nearest mode: two bound divides, then one read of the source pixel.
// Each box bound and each channel mean is found in the shared 27-step divider.
// Throughput: input stalls from a compute word until its result is taken.
// Reset: asynchronous active-low; sizes 1, area mode, alpha zero; frame store not cleared.
// ----------------------------------------------------------------------------
// image_area_average_scaler: box-filter image resize over a stored frame
// Load words write a source pixel; compute words return an averaged or copied pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module image_area_average_scaler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [8:0] src_x,
	input  logic [8:0] src_y,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	input  logic [7:0] in_alpha,
	input  logic [8:0] dst_x,
	input  logic [8:0] dst_y,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha,
	output logic [8:0] out_x,
	output logic [8:0] out_y
);
	import iaas_pkg::*;

	// configuration registers
	logic [9:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic       near_q, four_q;
	// effective sizes
	logic [9:0] w_eff, h_eff, dw_eff, dh_eff;

	state_t      state_q, state_d;
	logic [8:0]  dx_q, dy_q;
	logic [8:0]  xa_q, xb_q, ya_q, yb_q, cx_q, cy_q;
	logic [SumW-1:0] sum_q [4];
	logic [CntW-1:0] n_q;
	logic [1:0]  ch_q;
	logic        wait_q;
	logic [7:0]  res_q [4];
	logic        out_v_q;

	div_req_t dreq;
	div_rsp_t drsp;

	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 10'd1;
			src_h_q <= 10'd1;
			dst_w_q <= 10'd1;
			dst_h_q <= 10'd1;
			near_q  <= 1'b0;
			four_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegSrcW: src_w_q <= cfg_data;
				RegSrcH: src_h_q <= cfg_data;
				RegDstW: dst_w_q <= cfg_data;
				RegDstH: dst_h_q <= cfg_data;
				RegNear: near_q  <= cfg_data[0];
				RegFour: four_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero means one; clamp source sizes to the store
	always_comb begin
		w_eff  = (src_w_q == '0) ? 10'd1 : (src_w_q > 10'(MaxWidth))  ? 10'(MaxWidth)  : src_w_q;
		h_eff  = (src_h_q == '0) ? 10'd1 : (src_h_q > 10'(MaxHeight)) ? 10'(MaxHeight) : src_h_q;
		dw_eff = (dst_w_q == '0) ? 10'd1 : dst_w_q;
		dh_eff = (dst_h_q == '0) ? 10'd1 : dst_h_q;
	end

	wire in_acc  = in_valid && !in_stall;
	wire is_load = in_acc && !action;
	wire is_comp = in_acc && action;

	// idle means no compute in flight and output slot free
	assign in_stall = (state_q != ST_IDLE) || out_v_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (is_comp) state_d = ST_XA;
			ST_XA:   if (drsp.done) state_d = near_q ? ST_YA : ST_XB;
			ST_XB:   if (drsp.done) state_d = ST_YA;
			ST_YA:   if (drsp.done) state_d = near_q ? ST_RD : ST_YB;
			ST_YB:   if (drsp.done) state_d = ST_RD;
			ST_RD:   state_d = ST_ACC;
			ST_ACC:  if (near_q) state_d = ST_OUT;
				else if (cx_q == xb_q && cy_q == yb_q) state_d = ST_DIV;
				else state_d = ST_RD;
			ST_DIV:  if (drsp.done && ch_q == 2'd3) state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// divider requests: one per box bound, one per channel mean in area mode
	function automatic logic [8:0] clampc(input logic [DivNW-1:0] q, input logic [9:0] lim);
		logic [DivNW-1:0] last;
		last = DivNW'(lim) - DivNW'(1);
		return (q > last) ? last[8:0] : q[8:0];
	endfunction

	always_comb begin
		dreq = '0;
		case (state_q)
			ST_XA: begin
				dreq.dividend = DivNW'(dx_q) * DivNW'(w_eff);
				dreq.divisor  = DivDW'(dw_eff);
			end
			ST_XB: begin
				dreq.dividend = (DivNW'(dx_q) + DivNW'(1)) * DivNW'(w_eff);
				dreq.divisor  = DivDW'(dw_eff);
			end
			ST_YA: begin
				dreq.dividend = DivNW'(dy_q) * DivNW'(h_eff);
				dreq.divisor  = DivDW'(dh_eff);
			end
			ST_YB: begin
				dreq.dividend = (DivNW'(dy_q) + DivNW'(1)) * DivNW'(h_eff);
				dreq.divisor  = DivDW'(dh_eff);
			end
			ST_DIV: begin
				dreq.dividend = DivNW'(sum_q[ch_q]);
				dreq.divisor  = DivDW'(n_q);
			end
			default: ;
		endcase
		dreq.start = wait_q && (state_q != ST_IDLE) && (state_q != ST_RD)
			&& (state_q != ST_ACC) && (state_q != ST_OUT);
	end

	// wait_q issues a fresh divide on entering a divide state and after each channel result in ST_DIV
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= 1'b0;
		end else begin
			wait_q <= (state_d != state_q) || (state_q == ST_DIV && drsp.done);
		end
	end

	always_ff @(posedge clk) begin
		if (is_comp) begin
			dx_q <= dst_x;
			dy_q <= dst_y;
			n_q  <= '0;
			ch_q <= '0;
			for (int i = 0; i < 4; i++) sum_q[i] <= '0;
		end
		case (state_q)
			ST_XA: if (drsp.done) begin
				xa_q <= clampc(drsp.quot, w_eff);
				cx_q <= clampc(drsp.quot, w_eff);
			end
			ST_XB: if (drsp.done) xb_q <= clampc(drsp.quot, w_eff);
			ST_YA: if (drsp.done) begin
				ya_q <= clampc(drsp.quot, h_eff);
				cy_q <= clampc(drsp.quot, h_eff);
			end
			ST_YB: if (drsp.done) yb_q <= clampc(drsp.quot, h_eff);
			ST_ACC: begin
				if (near_q) begin
					for (int i = 0; i < 4; i++) res_q[i] <= ram_rd[8*i +: 8];
				end else begin
					for (int i = 0; i < 4; i++)
						sum_q[i] <= sum_q[i] + SumW'(ram_rd[8*i +: 8]);
					n_q <= n_q + CntW'(1);
					if (cx_q == xb_q) begin
						cx_q <= xa_q;
						cy_q <= cy_q + 9'd1;
					end else begin
						cx_q <= cx_q + 9'd1;
					end
				end
			end
			ST_DIV: if (drsp.done) begin
				res_q[ch_q] <= drsp.quot[7:0];
				ch_q <= ch_q + 2'd1;
			end
			default: ;
		endcase
	end

	iaas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign ram_we   = is_load;
	assign ram_addr = is_load ? {src_y, src_x} : {cy_q, cx_q};

	iaas_ram #(.Width(32), .Depth(MaxWidth * MaxHeight)) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({in_alpha, in_blue, in_green, in_red}),
		.rdata (ram_rd)
	);

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (state_q == ST_OUT) out_v_q <= 1'b1;
		else if (!out_stall) out_v_q <= 1'b0;
	end

	assign out_valid = out_v_q;
	assign out_red   = res_q[0];
	assign out_green = res_q[1];
	assign out_blue  = res_q[2];
	assign out_alpha = four_q ? res_q[3] : 8'd0;
	assign out_x     = dx_q;
	assign out_y     = dy_q;

	`IAAS_ASSERT(a_busy_stall, (state_q != ST_IDLE) |-> in_stall, "accepted during compute")
	`IAAS_ASSERT(a_out_once, (state_q == ST_OUT) |-> !out_v_q, "result overwritten")
	`IAAS_ASSERT(a_box_order, (state_q == ST_ACC && !near_q) |-> (xa_q <= xb_q), "box inverted")
endmodule

/* rtl/iaas_ram.sv */
// ----------------------------------------------------------------------------
// iaas_ram: generic single-port RAM
// One access per cycle at one address; read data is registered and shows the old word on a write.
// ----------------------------------------------------------------------------
module iaas_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/iaas_div.sv */
// ----------------------------------------------------------------------------
// iaas_div: shared restoring divider
// One quotient bit per cycle; done pulses the cycle after the last step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module iaas_div (
	input  logic              clk,
	input  logic              arst_n,
	input  iaas_pkg::div_req_t req,
	output iaas_pkg::div_rsp_t rsp
);
	import iaas_pkg::*;

	logic [DivNW-1:0]   quot_q;
	logic [DivDW:0]     rem_q;
	logic [DivDW-1:0]   dvs_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DivDW:0]     trial;

	assign trial = {rem_q[DivDW-1:0], quot_q[DivNW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DivCntW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivNW);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - DivCntW'(1);
				busy_q <= (cnt_q != DivCntW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q  <= trial - {1'b0, dvs_q};
				quot_q <= {quot_q[DivNW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[DivNW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	`IAAS_ASSERT(a_cnt_range, busy_q |-> (cnt_q != '0), "divider count ran out")
	`IAAS_ASSERT(a_done_end, rsp.done |=> !busy_q, "divider busy after done")
endmodule
